>>> rtl/core/qds_pkg.sv
package qds_pkg;

   // Default values of the top-level parameters.
   localparam int PERIOD_WIDTH_DEFAULT  = 32;
   localparam int CAPTURE_WIDTH_DEFAULT = 16;

   // Stream and register port widths.
   localparam int REQ_DATA_W  = 24;
   localparam int REQ_USER_W  = 1;
   localparam int RSP_DATA_W  = 104;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   // Field widths.
   localparam int CAP_FIELD_W   = 16;
   localparam int TICK_W        = 32;
   localparam int ERR_W         = 8;
   localparam int PER_W         = 32;
   localparam int PER_MAG_W     = 31;
   localparam int OUT16_W       = 16;
   localparam int NUMERATOR_W   = 24;
   localparam int UM_W          = 12;
   localparam int PRODUCT_W     = TICK_W + UM_W;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION_INVERT     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_NUMERATOR      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MICROMETERS_PER_TICK = 2'd2;

   // Register reset values.
   localparam logic [NUMERATOR_W-1:0] NUMERATOR_RESET = 24'd424779;
   localparam logic [UM_W-1:0]        UM_RESET        = 12'd425;

   // Saturation limits.
   localparam logic [ERR_W-1:0]     ERROR_MAX  = 8'd255;
   localparam logic [PER_MAG_W-1:0] PERIOD_MAX = 31'h7FFF_FFFF;
   localparam logic [OUT16_W-1:0]   POS_MAX    = 16'h7FFF;
   localparam logic [OUT16_W-1:0]   NEG_MIN    = 16'h8000;

   // Distance divider: micrometers to millimeters.
   localparam int DIST_DIV_W = 10;
   localparam logic [DIST_DIV_W-1:0] DIST_DIVISOR = 10'd1000;
   // Products at or above this magnitude give a quotient of 32768 or more, beyond the signed 16-bit range.
   localparam logic [PRODUCT_W-1:0] DIST_SAT_LIMIT = 44'd32768000;

   // Both divider lanes take this many dividend bits, one per cycle.
   localparam int DIV_STEPS = 25;

   // Quadrature step decoded from the previous and present phase pair.
   typedef enum logic [1:0] {
      STEP_INVALID,
      STEP_UP,
      STEP_DOWN
   } step_type;

   // Transition table indexed by {previous A, previous B, A, B}.
   function automatic step_type step_lookup(input logic [3:0] idx);
      step_type s;
      unique case (idx) inside
         4'd2, 4'd4, 4'd11, 4'd13: s = STEP_UP;
         4'd1, 4'd7, 4'd8, 4'd14:  s = STEP_DOWN;
         default:                  s = STEP_INVALID;
      endcase
      return s;
   endfunction

endpackage

>>> rtl/core/qds_serdiv.sv
// Restoring divider that retires one quotient bit per cycle.
module qds_serdiv #(
   parameter int NUM_W = 25,
   parameter int DEN_W = 31
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numerator,
   input  logic [DEN_W-1:0] denominator,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] count_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic             fits;

   // One step: bring down the next dividend bit and try to subtract.
   always_comb begin
      trial  = {rem_ff, num_ff[NUM_W-1]};
      fits   = (trial >= {1'b0, den_ff});
      rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
      num_in = {num_ff[NUM_W-2:0], 1'b0};
      quo_in = {quo_ff[NUM_W-2:0], fits};
   end

   // Step counter and completion pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Shift registers of the dividend, remainder and quotient.
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= numerator;
         den_ff <= denominator;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/core/quadrature_decoder_speed.sv
// Quadrature decoder with edge-period speed and distance for one wheel. Each request
// beat is one timer event (or a clear of the tick and error counts) and yields exactly
// one response beat with the tick count, error count, signed period, speed and distance.
// Each item runs through these steps before the next request is accepted: update the
// decoder state, multiply ticks by micrometers per tick, launch the dividers, run the
// two bit-serial divider lanes (speed numerator over period and product over 1000, one
// quotient bit per cycle each), and hand the result to the response register once that
// register is free. A finished beat waits in that register while the next request is taken.
// Configuration is written through csr_we/csr_index/csr_wdata; the user must write it
// only while no item is in flight, since the block itself does not enforce this.
module quadrature_decoder_speed #(
   parameter int PERIOD_WIDTH  = qds_pkg::PERIOD_WIDTH_DEFAULT,
   parameter int CAPTURE_WIDTH = qds_pkg::CAPTURE_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // overflow, capture_b, capture_a, capture_count[15:0], phase_a, phase_b, zero fill
   input  logic [qds_pkg::REQ_DATA_W-1:0]   req_tdata,
   // operation
   input  logic [qds_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tick_count[31:0], error_count[7:0], signed_period[31:0], speed[15:0],
   // distance_mm[15:0]
   output logic [qds_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_we,
   input  logic [qds_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [qds_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import qds_pkg::*;

   localparam int CAP_USED = (CAPTURE_WIDTH < CAP_FIELD_W) ? CAPTURE_WIDTH : CAP_FIELD_W;
   localparam int EXT_W    = (PERIOD_WIDTH > PER_MAG_W) ? PERIOD_WIDTH : PER_MAG_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_LAUNCH,
      ST_DIVIDE,
      ST_DELIVER
   } state_type;

   // Request fields.
   logic                   in_operation;
   logic                   in_overflow;
   logic                   in_capture_b;
   logic                   in_capture_a;
   logic [CAP_FIELD_W-1:0] in_capture_count;
   logic                   in_phase_a;
   logic                   in_phase_b;
   logic                   accept;

   // Configuration registers.
   logic                   invert_ff;
   logic [NUMERATOR_W-1:0] numerator_ff;
   logic [UM_W-1:0]        um_ff;

   // Decoder state.
   logic [1:0]              prev_phases_ff, prev_phases_in;
   logic                    first_ff, first_in;
   logic                    forward_ff, forward_in;
   logic [3:0]              flags_ff, flags_in;
   logic [PERIOD_WIDTH-1:0] acc_ff [4];
   logic [PERIOD_WIDTH-1:0] acc_in [4];
   logic [TICK_W-1:0]       tick_ff, tick_in;
   logic [ERR_W-1:0]        err_ff, err_in;
   logic [PER_W-1:0]        period_ff, period_in;

   // Arithmetic pipeline registers.
   logic [PRODUCT_W-1:0]    prod_mag_ff;
   logic                    dist_neg_ff;
   logic                    dist_sat_ff;
   logic [PER_MAG_W-1:0]    per_mag_ff;
   logic                    per_neg_ff;
   logic                    per_zero_ff;

   // Event decode temporaries.
   logic [3:0]              step_idx;
   step_type                step;
   logic [PERIOD_WIDTH-1:0] cval;
   logic [PERIOD_WIDTH-1:0] found;
   logic [EXT_W-1:0]        found_ext;
   logic [PER_MAG_W-1:0]    found_mag;
   logic [3:0]              flags_base;
   logic [1:0]              slot_b;
   logic [1:0]              slot_a;

   // Magnitudes for the multiply and divide.
   logic [TICK_W-1:0]       tick_mag;
   logic [PER_W-1:0]        period_abs;

   // Divider lanes and result shaping.
   logic                    div_start;
   logic                    spd_done;
   logic                    dst_done;
   logic [DIV_STEPS-1:0]    spd_quo;
   logic [DIV_STEPS-1:0]    dst_quo;
   logic [OUT16_W-1:0]      speed_val;
   logic [OUT16_W-1:0]      dist_val;

   state_type               state_ff;
   logic                    rsp_valid_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;
   logic                    rsp_free;

   assign in_operation     = req_tuser[0];
   assign in_overflow      = req_tdata[0];
   assign in_capture_b     = req_tdata[1];
   assign in_capture_a     = req_tdata[2];
   assign in_capture_count = req_tdata[18:3];
   assign in_phase_a       = req_tdata[19];
   assign in_phase_b       = req_tdata[20];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff    <= 1'b0;
         numerator_ff <= NUMERATOR_RESET;
         um_ff        <= UM_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DIRECTION_INVERT:     invert_ff    <= csr_wdata[0];
            CSR_SPEED_NUMERATOR:      numerator_ff <= csr_wdata[NUMERATOR_W-1:0];
            CSR_MICROMETERS_PER_TICK: um_ff        <= csr_wdata[UM_W-1:0];
            default: ;
         endcase
      end
   end

   // Next decoder state for one accepted event.
   always_comb begin
      prev_phases_in = prev_phases_ff;
      first_in       = first_ff;
      forward_in     = forward_ff;
      tick_in        = tick_ff;
      err_in         = err_ff;
      period_in      = period_ff;
      flags_in       = flags_ff;
      for (int i = 0; i < 4; i++) begin
         acc_in[i] = acc_ff[i];
      end

      step_idx   = {prev_phases_ff, in_phase_a, in_phase_b};
      step       = step_lookup(step_idx);
      cval       = (in_capture_a || in_capture_b) ?
                   PERIOD_WIDTH'(in_capture_count[CAP_USED-1:0]) : '0;
      slot_b     = in_phase_b ? 2'd0 : 2'd1;
      slot_a     = in_phase_a ? 2'd2 : 2'd3;
      flags_base = in_overflow ? 4'b0000 : flags_ff;
      found      = '0;
      found_ext  = '0;
      found_mag  = '0;

      if (in_operation) begin
         tick_in = '0;
         err_in  = '0;
      end else begin
         // Phase decode, skipped on overflow.
         if (!in_overflow) begin
            prev_phases_in = {in_phase_a, in_phase_b};
            if (first_ff) begin
               first_in = 1'b0;
            end else if (step == STEP_INVALID) begin
               if (err_ff != ERROR_MAX) begin
                  err_in = err_ff + 1'b1;
               end
            end else begin
               forward_in = (step == STEP_UP);
               if (forward_in != invert_ff) begin
                  tick_in = tick_ff + 1'b1;
               end else begin
                  tick_in = tick_ff - 1'b1;
               end
            end
         end

         // All edge accumulators gain the capture value.
         for (int i = 0; i < 4; i++) begin
            acc_in[i] = acc_ff[i] + cval;
         end
         flags_in = flags_base;

         // Capture on B first, then on A, so the A period wins.
         if (in_capture_b) begin
            if (flags_base[slot_b]) begin
               found = acc_in[slot_b];
            end
            acc_in[slot_b]   = '0;
            flags_in[slot_b] = 1'b1;
         end
         if (in_capture_a) begin
            if (flags_base[slot_a]) begin
               found = acc_in[slot_a];
            end
            acc_in[slot_a]   = '0;
            flags_in[slot_a] = 1'b1;
         end

         // Saturate the period magnitude and sign it by direction.
         found_ext = EXT_W'(found);
         if (found_ext > EXT_W'(PERIOD_MAX)) begin
            found_mag = PERIOD_MAX;
         end else begin
            found_mag = found_ext[PER_MAG_W-1:0];
         end
         if (forward_in != invert_ff) begin
            period_in = {1'b0, found_mag};
         end else begin
            period_in = PER_W'(-{1'b0, found_mag});
         end
      end
   end

   // Decoder state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_phases_ff <= 2'b00;
         first_ff       <= 1'b1;
         forward_ff     <= 1'b0;
         flags_ff       <= 4'b0000;
         tick_ff        <= '0;
         err_ff         <= '0;
         period_ff      <= '0;
         for (int i = 0; i < 4; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (accept) begin
         prev_phases_ff <= prev_phases_in;
         first_ff       <= first_in;
         forward_ff     <= forward_in;
         flags_ff       <= flags_in;
         tick_ff        <= tick_in;
         err_ff         <= err_in;
         period_ff      <= period_in;
         for (int i = 0; i < 4; i++) begin
            acc_ff[i] <= acc_in[i];
         end
      end
   end

   // Magnitudes of the tick count and the period.
   assign tick_mag   = tick_ff[TICK_W-1] ? TICK_W'(-tick_ff) : tick_ff;
   assign period_abs = period_ff[PER_W-1] ? PER_W'(-period_ff) : period_ff;

   // Multiply stage and divider operands.
   always_ff @(posedge clock) begin
      if (state_ff == ST_MULT) begin
         prod_mag_ff <= PRODUCT_W'(tick_mag) * PRODUCT_W'(um_ff);
         dist_neg_ff <= tick_ff[TICK_W-1];
         per_mag_ff  <= period_abs[PER_MAG_W-1:0];
         per_neg_ff  <= period_ff[PER_W-1];
         per_zero_ff <= (period_ff == '0);
      end
      if (state_ff == ST_LAUNCH) begin
         dist_sat_ff <= (prod_mag_ff >= DIST_SAT_LIMIT);
      end
   end

   assign div_start = (state_ff == ST_LAUNCH);

   // Speed lane: numerator over the period magnitude.
   qds_serdiv #(
      .NUM_W (DIV_STEPS),
      .DEN_W (PER_MAG_W)
   ) u_speed_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (DIV_STEPS'(numerator_ff)),
      .denominator (per_mag_ff),
      .done        (spd_done),
      .quotient    (spd_quo)
   );

   // Distance lane: product magnitude over 1000.
   qds_serdiv #(
      .NUM_W (DIV_STEPS),
      .DEN_W (DIST_DIV_W)
   ) u_dist_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (prod_mag_ff[DIV_STEPS-1:0]),
      .denominator (DIST_DIVISOR),
      .done        (dst_done),
      .quotient    (dst_quo)
   );

   // Apply signs and 16-bit saturation to the quotients.
   always_comb begin
      if (per_zero_ff) begin
         speed_val = '0;
      end else if (!per_neg_ff) begin
         speed_val = (spd_quo > DIV_STEPS'(POS_MAX)) ? POS_MAX : spd_quo[OUT16_W-1:0];
      end else if (spd_quo > DIV_STEPS'(NEG_MIN)) begin
         speed_val = NEG_MIN;
      end else begin
         speed_val = OUT16_W'(-spd_quo[OUT16_W-1:0]);
      end

      if (dist_sat_ff) begin
         dist_val = dist_neg_ff ? NEG_MIN : POS_MAX;
      end else if (dist_neg_ff) begin
         dist_val = OUT16_W'(-dst_quo[OUT16_W-1:0]);
      end else begin
         dist_val = dst_quo[OUT16_W-1:0];
      end
   end

   // Sequencer and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A taken beat empties the register unless a new one lands in it.
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_DELIVER)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_MULT;
               end
            end
            ST_MULT: begin
               state_ff <= ST_LAUNCH;
            end
            ST_LAUNCH: begin
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (spd_done && dst_done) begin
                  state_ff <= ST_DELIVER;
               end
            end
            ST_DELIVER: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {dist_val, speed_val, period_ff, err_ff, tick_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
